### rtl/swg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swg_pkg - shared types and constants for the swipe gesture counter
// Sample and tally widths, heading and axis codes, result formatting.
// ----------------------------------------------------------------------------
package swg_pkg;

    localparam int SAMPLE_BITS  = 16;   // 8 .. 16
    localparam int TALLY_BITS   = 8;    // 4 .. 16
    localparam int READING_BITS = 16;
    localparam int THRESH_BITS  = 16;
    localparam int TOTAL_BITS   = 8;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(105);

    // compare width: wide enough for prior plus threshold without overflow
    localparam int CMP_BITS   = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 1;
    localparam int TOTAL_EXT  = (TALLY_BITS > TOTAL_BITS) ? TALLY_BITS : TOTAL_BITS;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TALLY_BITS-1:0]  t_tally;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_head;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2
    } t_axis;

    // low TOTAL_BITS of the tally, zero-extended when the tally is narrower
    function automatic logic [TOTAL_BITS-1:0] to_total(input t_tally tally);
        logic [TOTAL_EXT-1:0] ext;
        ext = TOTAL_EXT'(tally);
        return ext[TOTAL_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/swg_axis_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swg_axis_class - movement classifier for one slider axis
// Rising when now exceeds before plus threshold, falling when now is below
// before minus threshold, otherwise still.
// ----------------------------------------------------------------------------
module swg_axis_class
    import swg_pkg::*;
(
    input  wire t_sample                 i_now,
    input  wire t_sample                 i_before,
    input  wire logic [THRESH_BITS-1:0]  i_thresh,
    output t_head                        o_head
);

    logic [CMP_BITS-1:0] now_w;
    logic [CMP_BITS-1:0] before_w;
    logic [CMP_BITS-1:0] thresh_w;
    logic                rising;
    logic                falling;

    assign now_w    = CMP_BITS'(i_now);
    assign before_w = CMP_BITS'(i_before);
    assign thresh_w = CMP_BITS'(i_thresh);

    // now < before - thresh rewritten as now + thresh < before: no negatives
    assign rising  = now_w > (before_w + thresh_w);
    assign falling = (now_w + thresh_w) < before_w;

    always_comb begin
        if (rising) begin
            o_head = HEAD_UP;
        end else if (falling) begin
            o_head = HEAD_DOWN;
        end else begin
            o_head = HEAD_NONE;
        end
    end

endmodule
`default_nettype wire

### rtl/swipe_gesture_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swipe_gesture_counter - counts repeated swipes on a two-axis touch slider
// Classifies each reading pair per axis, tracks the active axis and heading,
// and outputs a result per beat: the swipe count at a direction reversal, else zero.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_x_reading, i_y_reading
//  output    o_out_valid / i_out_stall  o_swipe_total
//  config    i_cfg_we                   i_cfg_data (move threshold)
//
//  One beat per cycle sustained while the output is not stalled; a beat passes
//  the input register, then classify/update logic into the state and result registers.
//  Reset clears the pipeline valids, the axis state and loads threshold 105.
//  A stalled output holds the result register; the input register still
//  loads when empty, then o_in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module swipe_gesture_counter
    import swg_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [THRESH_BITS-1:0]   i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [READING_BITS-1:0]  i_x_reading,
    input  wire logic [READING_BITS-1:0]  i_y_reading,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [TOTAL_BITS-1:0]         o_swipe_total
);

    logic [THRESH_BITS-1:0] r_thresh;
    logic                   r_in_valid;
    t_sample                r_x;
    t_sample                r_y;
    logic                   r_out_valid;
    logic [TOTAL_BITS-1:0]  r_total;

    t_sample r_prior_x, n_prior_x;
    t_sample r_prior_y, n_prior_y;
    t_head   r_head_x,  n_head_x;
    t_head   r_head_y,  n_head_y;
    t_tally  r_tally,   n_tally;
    t_axis   r_axis,    n_axis;
    t_tally  n_report;

    t_head   dx;
    t_head   dy;
    t_axis   axis;
    t_head   dir;
    t_head   head;
    logic    advance;
    logic    fire;
    logic    in_take;

    // output register free or being drained this cycle
    assign advance    = !(r_out_valid && i_out_stall);
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    swg_axis_class u_class_x (
        .i_now    (r_x),
        .i_before (r_prior_x),
        .i_thresh (r_thresh),
        .o_head   (dx)
    );

    swg_axis_class u_class_y (
        .i_now    (r_y),
        .i_before (r_prior_y),
        .i_thresh (r_thresh),
        .o_head   (dy)
    );

    always_comb begin
        n_prior_x = r_x;
        n_prior_y = r_y;
        n_head_x  = r_head_x;
        n_head_y  = r_head_y;
        n_tally   = r_tally;
        n_axis    = r_axis;
        n_report  = '0;
        axis      = AXIS_NONE;
        dir       = (r_axis == AXIS_X) ? dx : dy;
        head      = (r_axis == AXIS_X) ? r_head_x : r_head_y;

        if (dx != HEAD_NONE && dy == HEAD_NONE) begin
            axis = AXIS_X;
        end else if (dy != HEAD_NONE && dx == HEAD_NONE) begin
            axis = AXIS_Y;
        end else begin
            axis = AXIS_NONE;
        end

        if (dx != HEAD_NONE || dy != HEAD_NONE) begin
            if (axis != r_axis) begin
                // axis change: restart count, record both directions
                n_tally  = '0;
                n_axis   = axis;
                n_head_x = dx;
                n_head_y = dy;
            end else if (axis == AXIS_NONE) begin
                // diagonal again: drop the count, keep the headings
                n_tally = '0;
            end else begin
                if (dir != head && head != HEAD_NONE) begin
                    n_report = r_tally;
                    n_tally  = '0;
                end else begin
                    n_tally = r_tally + t_tally'(1);
                end
                if (axis == AXIS_X) begin
                    n_head_x = dir;
                end else begin
                    n_head_y = dir;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prior_x   <= '0;
            r_prior_y   <= '0;
            r_head_x    <= HEAD_NONE;
            r_head_y    <= HEAD_NONE;
            r_tally     <= '0;
            r_axis      <= AXIS_NONE;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_prior_x <= n_prior_x;
                r_prior_y <= n_prior_y;
                r_head_x  <= n_head_x;
                r_head_y  <= n_head_y;
                r_tally   <= n_tally;
                r_axis    <= n_axis;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x <= i_x_reading[SAMPLE_BITS-1:0];
            r_y <= i_y_reading[SAMPLE_BITS-1:0];
        end
        if (fire) begin
            r_total <= to_total(n_report);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_swipe_total = r_total;

    // no axis selected means the count has been dropped
    a_none_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis == AXIS_NONE |-> r_tally == '0)
        else $error("tally nonzero with no axis selected");

    // a selected axis always carries a direction on that axis
    a_x_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis == AXIS_X |-> r_head_x != HEAD_NONE)
        else $error("X axis selected without X heading");

    a_y_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis == AXIS_Y |-> r_head_y != HEAD_NONE)
        else $error("Y axis selected without Y heading");

    // input side stalls only when a beat is stuck in the input register
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled while pipeline can move");

    // a taken input beat shows up on the output in the cycle after it leaves stage one
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed beat lost");

endmodule
`default_nettype wire
